// ===== rtl/core/utilization_window_monitor_core_macros.svh =====
// Assertion helpers shared by the monitor RTL.
`ifndef UTILIZATION_WINDOW_MONITOR_CORE_MACROS_SVH
`define UTILIZATION_WINDOW_MONITOR_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define UWM_ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define UWM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/uwm_pkg.sv =====
`default_nettype none

package uwm_pkg;

  localparam int unsigned USAGE_W   = 14;
  localparam int unsigned Q_STEPS   = 14;
  localparam int unsigned STEP_W    = 4;
  localparam int unsigned SUM_W     = 21;
  localparam int unsigned CNT_W     = 7;
  localparam logic [USAGE_W-1:0] USAGE_FULL = 14'd10000;
  localparam logic [CNT_W-1:0]   WL_RESET   = 7'd60;
  localparam logic [STEP_W-1:0]  LAST_STEP  = 4'(Q_STEPS - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DI,
    S_DT,
    S_BUSY,
    S_MUL,
    S_DIV,
    S_PUSH,
    S_SCAN,
    S_DONE
  } state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

endpackage

`default_nettype wire

// ===== rtl/core/uwm_ram.sv =====
`default_nettype none

module uwm_ram #(
  parameter int unsigned WIDTH = 14,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/uwm_alu.sv =====
`default_nettype none

module uwm_alu #(
  parameter int unsigned W = 78
) (
  input  uwm_pkg::alu_op_t op,
  input  logic [W-1:0]     a,
  input  logic [W-1:0]     b,
  output logic [W-1:0]     res,
  output logic             borrow
);

  import uwm_pkg::*;

  logic         is_sub;
  logic [W-1:0] b_x;
  logic [W:0]   full;

  assign is_sub = (op == ALU_SUB);
  assign b_x    = is_sub ? ~b : b;
  assign full   = {1'b0, a} + {1'b0, b_x} + (W+1)'(is_sub);
  assign res    = full[W-1:0];
  // subtract borrows when the carry out of the top bit is missing
  assign borrow = is_sub & ~full[W];

endmodule

`default_nettype wire

// ===== rtl/core/utilization_window_monitor_core.sv =====
`default_nettype none
`include "utilization_window_monitor_core_macros.svh"

// Utilization window monitor. Each input beat carries cumulative idle and total
// tick counters plus a valid flag; the first valid beat after reset only primes
// the stored counters and yields no result, each other beat yields one result
// with the current usage (hundredths of a percent), the truncated window mean,
// the window peak and the number of samples held. The deltas, products, divides
// and window sums run on one shared add/subtract unit under a sequencer: a valid
// sample passes through 3 delta steps, a 14-step shift-add multiply by 10000, a
// 14-step restoring divide, a window scan of one history read per held sample,
// and a 14-step divide for the mean; a valid sample whose busy delta is zero or
// negative skips the multiply and the first divide; an invalid sample skips the
// first three parts. A priming sample is taken without leaving the idle state.
// The input is not ready while a sample is in work, nor during reset; a finished
// result sits in an output register while the next sample is taken. The history
// memory needs no clearing pass.
module utilization_window_monitor_core #(
  parameter int unsigned HISTORY_DEPTH = 64,
  parameter int unsigned COUNTER_WIDTH = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // idle_ticks [63:0], total_ticks [127:64]
  input  logic [0:0]   s_axis_tuser,  // sample_valid [0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [55:0]  m_axis_tdata,  // usage_now [13:0], usage_average [27:14],
                                      // usage_peak [41:28], samples_held [48:42]
  input  logic         cfg_wr_en,
  input  logic [6:0]   cfg_wr_data    // window_length
);

  import uwm_pkg::*;

  localparam int unsigned AW     = COUNTER_WIDTH + Q_STEPS;
  localparam int unsigned ADDR_W = $clog2(HISTORY_DEPTH);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(HISTORY_DEPTH - 1);

  state_t state, state_next;

  logic [CNT_W-1:0]         window_length;
  logic                     primed;
  logic [COUNTER_WIDTH-1:0] last_idle, last_total;
  logic [COUNTER_WIDTH-1:0] in_idle, in_total;
  logic [COUNTER_WIDTH-1:0] opnd;
  logic [COUNTER_WIDTH-1:0] div_reg;
  logic [AW-1:0]            acc, rem;
  logic [USAGE_W-1:0]       quo;
  logic [STEP_W-1:0]        step;
  logic                     avg_phase;
  logic [USAGE_W-1:0]       usage, peak;
  logic [SUM_W-1:0]         sum;
  logic [CNT_W-1:0]         count, scan_n;
  logic [ADDR_W-1:0]        head, rd_addr;

  logic [USAGE_W-1:0] out_now, out_avg, out_peak;
  logic [CNT_W-1:0]   out_held;
  logic               m_valid;

  alu_op_t            alu_op;
  logic [AW-1:0]      alu_a, alu_b, alu_res;
  logic               alu_borrow;
  logic               ram_we;
  logic [USAGE_W-1:0] rd_data;
  logic               out_load;

  logic [AW-1:0]      rem_sh;
  logic [USAGE_W-1:0] quo_next;
  logic [CNT_W-1:0]   wl_eff, count_new;
  logic [CNT_W:0]     count_inc;

  uwm_alu #(.W(AW)) u_alu (
    .op     (alu_op),
    .a      (alu_a),
    .b      (alu_b),
    .res    (alu_res),
    .borrow (alu_borrow)
  );

  uwm_ram #(.WIDTH(USAGE_W), .DEPTH(HISTORY_DEPTH)) u_hist (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (head),
    .wr_data (usage),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rem_sh   = {rem[AW-2:0], acc[Q_STEPS-1]};
  assign quo_next = {quo[USAGE_W-2:0], ~alu_borrow};

  assign wl_eff = (window_length == '0) ? CNT_W'(1) :
                  (32'(window_length) > HISTORY_DEPTH) ? CNT_W'(HISTORY_DEPTH) :
                  window_length;
  assign count_inc = {1'b0, count} + (CNT_W+1)'(1);
  assign count_new = (count_inc > {1'b0, wl_eff}) ? wl_eff : count_inc[CNT_W-1:0];

  assign out_load = (state == S_DONE) && (!m_valid || m_axis_tready);

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    alu_op        = ALU_ADD;
    alu_a         = '0;
    alu_b         = '0;
    unique case (state)
      S_IDLE: begin
        s_axis_tready = !rst;
        if (s_axis_tvalid) begin
          if (!s_axis_tuser[0]) begin
            state_next = S_PUSH;
          end else if (primed) begin
            state_next = S_DI;
          end
        end
      end
      S_DI: begin
        alu_op     = ALU_SUB;
        alu_a      = AW'(in_idle);
        alu_b      = AW'(last_idle);
        state_next = S_DT;
      end
      S_DT: begin
        alu_op     = ALU_SUB;
        alu_a      = AW'(in_total);
        alu_b      = AW'(last_total);
        state_next = S_BUSY;
      end
      S_BUSY: begin
        // busy = dt - di; a zero or negative result means no usage
        alu_op = ALU_SUB;
        alu_a  = AW'(div_reg);
        alu_b  = AW'(opnd);
        if (alu_borrow || alu_res == '0) begin
          state_next = S_PUSH;
        end else begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        alu_op = ALU_ADD;
        alu_a  = {acc[AW-2:0], 1'b0};
        alu_b  = USAGE_FULL[step] ? AW'(opnd) : '0;
        if (step == '0) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        alu_op = ALU_SUB;
        alu_a  = rem_sh;
        alu_b  = AW'(div_reg);
        if (step == '0) begin
          state_next = avg_phase ? S_DONE : S_PUSH;
        end
      end
      S_PUSH: begin
        ram_we     = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        alu_op = ALU_ADD;
        alu_a  = AW'(sum);
        alu_b  = AW'(rd_data);
        if (scan_n == count) begin
          state_next = S_DIV;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WL_RESET;
      primed        <= 1'b0;
      last_idle     <= '0;
      last_total    <= '0;
      head          <= '0;
      count         <= '0;
      m_valid       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        window_length <= cfg_wr_data;
      end
      if (out_load) begin
        m_valid  <= 1'b1;
        out_now  <= usage;
        out_avg  <= quo;
        out_peak <= peak;
        out_held <= count;
      end else if (m_axis_tready) begin
        m_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            in_idle  <= s_axis_tdata[COUNTER_WIDTH-1:0];
            in_total <= s_axis_tdata[64 +: COUNTER_WIDTH];
            usage    <= '0;
            // first valid sample only primes the stored counters
            if (s_axis_tuser[0] && !primed) begin
              last_idle  <= s_axis_tdata[COUNTER_WIDTH-1:0];
              last_total <= s_axis_tdata[64 +: COUNTER_WIDTH];
              primed     <= 1'b1;
            end
          end
        end
        S_DI: begin
          opnd      <= alu_res[COUNTER_WIDTH-1:0];
          last_idle <= in_idle;
        end
        S_DT: begin
          div_reg    <= alu_res[COUNTER_WIDTH-1:0];
          last_total <= in_total;
        end
        S_BUSY: begin
          opnd <= alu_res[COUNTER_WIDTH-1:0];
          acc  <= '0;
          step <= LAST_STEP;
        end
        S_MUL: begin
          if (step == '0) begin
            acc       <= alu_res;
            rem       <= alu_res >> Q_STEPS;
            quo       <= '0;
            avg_phase <= 1'b0;
            step      <= LAST_STEP;
          end else begin
            acc  <= alu_res;
            step <= step - STEP_W'(1);
          end
        end
        S_DIV: begin
          if (!alu_borrow) begin
            rem <= alu_res;
          end else begin
            rem <= rem_sh;
          end
          quo  <= quo_next;
          acc  <= {acc[AW-2:0], 1'b0};
          step <= step - STEP_W'(1);
          if (step == '0 && !avg_phase) begin
            usage <= quo_next;
          end
        end
        S_PUSH: begin
          head    <= (head == LAST_ADDR) ? '0 : head + ADDR_W'(1);
          count   <= count_new;
          rd_addr <= head;
          sum     <= '0;
          peak    <= '0;
          scan_n  <= '0;
        end
        S_SCAN: begin
          // issue one history read per cycle, newest first; the read data is registered and lands in the next cycle
          if (scan_n != count) begin
            rd_addr <= (rd_addr == '0) ? LAST_ADDR : rd_addr - ADDR_W'(1);
          end
          if (scan_n != '0) begin
            sum <= alu_res[SUM_W-1:0];
            if (rd_data > peak) begin
              peak <= rd_data;
            end
          end
          scan_n <= scan_n + CNT_W'(1);
          if (scan_n == count) begin
            acc       <= alu_res;
            rem       <= alu_res >> Q_STEPS;
            div_reg   <= COUNTER_WIDTH'(count);
            quo       <= '0;
            avg_phase <= 1'b1;
            step      <= LAST_STEP;
          end
        end
        S_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {7'b0, out_held, out_peak, out_avg, out_now};

  `UWM_ASSERT_HOLDS(a_div_rem_bound, clk, rst, state == S_DIV, rem < AW'(div_reg), "divide remainder not below divisor")
  `UWM_ASSERT_HOLDS(a_held_range, clk, rst, m_axis_tvalid, (out_held != '0) && (32'(out_held) <= HISTORY_DEPTH), "samples held out of range")
  `UWM_ASSERT_NEXT(a_result_loaded, clk, rst, out_load, m_axis_tvalid && (state == S_IDLE), "result not presented after load")

endmodule

`default_nettype wire

// ===== sim/utilization_window_monitor_core_test.sv =====
`timescale 1ns / 1ps

module utilization_window_monitor_core_test;
  import uwm_pkg::*;

  typedef struct {
    logic [63:0] idle_ticks;
    logic [63:0] total_ticks;
    logic        sample_valid;
  } sample_t;

  typedef struct {
    logic [USAGE_W-1:0] usage_now;
    logic [USAGE_W-1:0] usage_average;
    logic [USAGE_W-1:0] usage_peak;
    logic [CNT_W-1:0]   samples_held;
  } report_t;

  localparam int unsigned HIST_DEPTH    = 64;
  localparam int unsigned GAP_MAX       = 12;
  localparam int unsigned SETTLE_CYCLES = 150;
  localparam int unsigned QUIET_LIMIT   = 3000;
  localparam int unsigned PHASE_ITEMS   = 140;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic [0:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [55:0]  m_axis_tdata;
  logic         cfg_wr_en = 1'b0;
  logic [6:0]   cfg_wr_data = '0;

  utilization_window_monitor_core dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor state, at its reset values
  logic [63:0]        prev_idle = '0;
  logic [63:0]        prev_total = '0;
  bit                 counters_primed = 1'b0;
  logic [6:0]         window_reg = WL_RESET;
  logic [USAGE_W-1:0] usage_history[$];  // newest at the back, one entry per held sample
  report_t            pending_reports[$];

  sample_t            sample_queue[$];
  logic [63:0]        gen_idle = '0;
  logic [63:0]        gen_total = '0;

  int unsigned samples_accepted = 0;
  int unsigned failed_reads = 0;
  int unsigned reports_checked = 0;
  int unsigned window_settings = 1;
  int unsigned failures = 0;

  task automatic predict_usage_window(input sample_t s);
    logic [63:0]        idle_delta;
    logic [63:0]        total_delta;
    logic [127:0]       scaled;
    logic [USAGE_W-1:0] usage;
    int unsigned        win;
    int unsigned        sum;
    int unsigned        peak;
    report_t            r;
    usage = '0;
    if (s.sample_valid) begin
      if (!counters_primed) begin
        prev_idle = s.idle_ticks;
        prev_total = s.total_ticks;
        counters_primed = 1'b1;
        return;
      end
      idle_delta = s.idle_ticks - prev_idle;
      total_delta = s.total_ticks - prev_total;
      if (total_delta != 0 && idle_delta < total_delta) begin
        scaled = 128'(total_delta - idle_delta) * 128'(USAGE_FULL);
        usage = USAGE_W'(scaled / 128'(total_delta));
      end
      prev_idle = s.idle_ticks;
      prev_total = s.total_ticks;
    end
    win = (window_reg == 0) ? 1 : (window_reg > HIST_DEPTH) ? HIST_DEPTH : window_reg;
    usage_history = {usage_history, usage};
    // drop the oldest samples once the window is full or has shrunk
    while (usage_history.size() > win) usage_history.delete(0);
    sum = 0;
    peak = 0;
    foreach (usage_history[i]) begin
      sum += usage_history[i];
      if (usage_history[i] > peak) peak = usage_history[i];
    end
    r.usage_now = usage;
    r.usage_average = USAGE_W'(sum / usage_history.size());
    r.usage_peak = USAGE_W'(peak);
    r.samples_held = CNT_W'(usage_history.size());
    pending_reports = {pending_reports, r};
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic queue_counters(input logic [63:0] idle_v, input logic [63:0] total_v,
                                input logic readable);
    sample_t s;
    s.idle_ticks = idle_v;
    s.total_ticks = total_v;
    s.sample_valid = readable;
    sample_queue = {sample_queue, s};
    if (readable) begin
      gen_idle = idle_v;
      gen_total = total_v;
    end
  endtask

  task automatic queue_deltas(input logic [63:0] idle_step, input logic [63:0] total_step);
    queue_counters(gen_idle + idle_step, gen_total + total_step, 1'b1);
  endtask

  // Mostly well-formed counter advances; the rest are failed reads, jumps and odd deltas.
  task automatic queue_random_sample();
    int unsigned pick;
    logic [63:0] dt;
    logic [63:0] di;
    pick = $urandom_range(0, 99);
    dt = rand64() >> $urandom_range(0, 63);
    if (dt == 0) dt = 1;
    di = (dt == '1) ? rand64() : rand64() % (dt + 64'd1);
    if (pick < 8) queue_counters(rand64(), rand64(), 1'b0);
    else if (pick < 13) queue_counters(rand64(), rand64(), 1'b1);
    else if (pick < 16) queue_deltas(rand64() >> $urandom_range(0, 63), '0);
    else if (pick < 20) queue_deltas(dt + $urandom_range(0, 50), dt);
    else if (pick < 24) queue_deltas('0, dt);
    else queue_deltas(di, dt);
  endtask

  function automatic void compare_field(input string field, input logic [13:0] want,
                                        input logic [13:0] got);
    if (got !== want) begin
      $error("%s expected %0d got %0d", field, want, got);
      failures++;
    end
  endfunction

  task automatic check_report(input logic [55:0] beat);
    report_t want;
    if (pending_reports.size() == 0) begin
      $error("result beat %h with no result pending", beat);
      failures++;
      return;
    end
    want = pending_reports[0];
    pending_reports.delete(0);
    reports_checked++;
    compare_field("usage_now", want.usage_now, beat[13:0]);
    compare_field("usage_average", want.usage_average, beat[27:14]);
    compare_field("usage_peak", want.usage_peak, beat[41:28]);
    compare_field("samples_held", 14'(want.samples_held), 14'(beat[48:42]));
  endtask

  // Sender
  sample_t     sample_in_flight;
  bit          sending = 1'b0;
  bit          send_calm = 1'b0;
  int unsigned send_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (sending && s_axis_tready) begin
        predict_usage_window(sample_in_flight);
        samples_accepted++;
        if (!sample_in_flight.sample_valid) failed_reads++;
        sending = 1'b0;
        if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
        send_gap = send_calm ? 0 : $urandom_range(0, GAP_MAX);
      end
      if (!sending) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (sample_queue.size() > 0) begin
          sample_in_flight = sample_queue[0];
          sample_queue.delete(0);
          sending = 1'b1;
          s_axis_tdata <= {sample_in_flight.total_ticks, sample_in_flight.idle_ticks};
          s_axis_tuser <= sample_in_flight.sample_valid;
        end
      end
      s_axis_tvalid <= sending;
    end
  end

  // Receiver: a drawn stall runs down only while a result is offered
  bit          recv_calm = 1'b0;
  int unsigned recv_stall = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_report(m_axis_tdata);
        if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
        recv_stall = recv_calm ? 0 : $urandom_range(0, GAP_MAX);
      end else if (m_axis_tvalid && recv_stall > 0) begin
        recv_stall--;
      end
      m_axis_tready <= (recv_stall == 0);
    end
  end

  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || cfg_wr_en || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $error("no beat moved for %0d cycles, %0d results outstanding", QUIET_LIMIT,
             pending_reports.size());
      $display("FAIL utilization_window_monitor_core");
      $finish;
    end
  end

  task automatic wait_until_drained();
    while (sample_queue.size() != 0 || sending || pending_reports.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_window_phase(input logic [6:0] wl);
    wait_until_drained();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= wl;
    window_reg = wl;
    window_settings++;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    repeat (PHASE_ITEMS) queue_random_sample();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // failed reads before priming still report
    queue_counters(rand64(), rand64(), 1'b0);
    queue_counters('1, '1, 1'b0);
    queue_counters('0, '0, 1'b1);
    queue_deltas('0, '0);
    queue_deltas(64'd100, 64'd100);
    queue_deltas(64'd200, 64'd100);
    queue_deltas('0, 64'd1);
    queue_deltas(64'd1, 64'd3);
    queue_deltas('0, '1);
    queue_deltas(64'h8000_0000_0000_0000, '1);
    queue_deltas('1, '1);
    queue_counters('1, '1, 1'b1);
    queue_deltas(64'd5, 64'd10);
    queue_counters(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 1'b1);
    queue_deltas(64'hffff_ffff, 64'h1_0000_0000);
    queue_counters('0, '1, 1'b0);
    queue_deltas(64'd3, 64'd7);
    queue_deltas(64'd1, '1);
    queue_deltas(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    repeat (PHASE_ITEMS) queue_random_sample();

    run_window_phase(7'd127);
    run_window_phase(7'd64);
    run_window_phase(7'd1);
    run_window_phase(7'd0);
    run_window_phase(7'd5);
    run_window_phase(7'd33);
    run_window_phase(7'd2);
    run_window_phase(7'd64);
    run_window_phase(7'd12);
    run_window_phase(7'($urandom_range(0, 127)));
    wait_until_drained();

    $display("Covered %0d samples (%0d failed reads) over %0d window lengths;",
             samples_accepted, failed_reads, window_settings);
    $display("%0d results checked, %0d mismatches.", reports_checked, failures);
    if (failures == 0) begin
      $display("PASS utilization_window_monitor_core");
    end else begin
      $display("FAIL utilization_window_monitor_core");
    end
    $finish;
  end

endmodule

// ===== utilization_window_monitor_core.f =====
+incdir+rtl/core
rtl/core/uwm_pkg.sv
rtl/core/uwm_ram.sv
rtl/core/uwm_alu.sv
rtl/core/utilization_window_monitor_core.sv
sim/utilization_window_monitor_core_test.sv
